[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion helper macros used by csv_stream_tokenizer_unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/csvtok_pkg.sv]
// ---------------------------------------------------------------------------
// csvtok_pkg
// Types and character codes for the CSV stream tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none

package csvtok_pkg;

    // Character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Token kinds
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_FIELD = 2'd1,
        KIND_ROW   = 2'd2
    } kind_t;

    // Parser flags
    typedef struct packed {
        logic quoted_mode;
        logic quote_pending;
        logic cr_pending;
        logic field_has_data;
        logic row_has_field;
    } parse_state_t;

    // One output token
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        kind_t      kind;
    } token_t;

endpackage

`default_nettype wire

[rtl/csvtok_decode.sv]
// ---------------------------------------------------------------------------
// csvtok_decode
// Combinational step: classifies one byte, or the end of input, against the
// parser flags and produces the next flags and at most one token.
// ---------------------------------------------------------------------------
`default_nettype none

module csvtok_decode (
    input  wire logic                      [7:0] in_byte,
    input  wire logic                            end_of_input,
    input  wire csvtok_pkg::parse_state_t        state,
    output csvtok_pkg::parse_state_t             state_next,
    output csvtok_pkg::token_t                   token
);

    logic quoted;
    logic skip_lf;

    always_comb
    begin
        state_next = state;
        token      = '{emit: 1'b0, data: 8'h00, kind: csvtok_pkg::KIND_DATA};
        quoted     = state.quoted_mode;
        skip_lf    = 1'b0;

        if (end_of_input)
        begin
            // flush a final row only if it carries something
            state_next = '0;
            token.emit = state.field_has_data | state.row_has_field;
            token.kind = csvtok_pkg::KIND_ROW;
        end
        else
        begin
            // LF right after a row-ending CR is dropped
            state_next.cr_pending = 1'b0;
            skip_lf = state.cr_pending && (in_byte == csvtok_pkg::CH_LF);

            if (!skip_lf)
            begin
                state_next.quote_pending = 1'b0;
                if (state.quote_pending && (in_byte == csvtok_pkg::CH_QUOTE))
                begin
                    // doubled quote inside quotes: literal quote
                    state_next.field_has_data = 1'b1;
                    token.emit = 1'b1;
                    token.data = csvtok_pkg::CH_QUOTE;
                end
                else
                begin
                    // any other byte after a held quote closes the quotes
                    if (state.quote_pending)
                        quoted = 1'b0;

                    if (in_byte == csvtok_pkg::CH_QUOTE)
                    begin
                        if (quoted)
                            state_next.quote_pending = 1'b1;
                        else
                            quoted = 1'b1;
                    end
                    else if (!quoted && (in_byte == csvtok_pkg::CH_COMMA))
                    begin
                        state_next.field_has_data = 1'b0;
                        state_next.row_has_field  = 1'b1;
                        token.emit = 1'b1;
                        token.kind = csvtok_pkg::KIND_FIELD;
                    end
                    else if (!quoted && ((in_byte == csvtok_pkg::CH_CR) ||
                                         (in_byte == csvtok_pkg::CH_LF)))
                    begin
                        state_next.field_has_data = 1'b0;
                        state_next.row_has_field  = 1'b0;
                        state_next.cr_pending     = (in_byte == csvtok_pkg::CH_CR);
                        token.emit = 1'b1;
                        token.kind = csvtok_pkg::KIND_ROW;
                    end
                    else
                    begin
                        state_next.field_has_data = 1'b1;
                        token.emit = 1'b1;
                        token.data = in_byte;
                    end
                    state_next.quoted_mode = quoted;
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/csv_stream_tokenizer_unit.sv]
// A byte reaches the output port via the input register, then the output register.
// Throughput: one byte per cycle unless the token output stalls; an input register
//   and an output register let a new byte enter while the previous token waits to be taken.
// A byte that yields no token (opening quote, swallowed LF) still takes its slot.
// Reset (rst_n low, asynchronous): parser flags cleared, both stages empty.
// ---------------------------------------------------------------------------
// csv_stream_tokenizer_unit
// Streaming CSV tokenizer: bytes in, data / field-end / row-end tokens out.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module csv_stream_tokenizer_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // end_of_input
    // token stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [1:0]      m_tuser    // [1:0] out_kind
);

    logic                     in_valid_reg;
    logic [7:0]               in_byte_reg;
    logic                     in_end_reg;
    csvtok_pkg::parse_state_t state_reg;
    csvtok_pkg::parse_state_t state_next;
    csvtok_pkg::token_t       token;
    logic                     out_valid_reg;
    logic [7:0]               out_byte_reg;
    csvtok_pkg::kind_t        out_kind_reg;
    logic                     out_free;
    logic                     advance;

    // output slot can take a token this cycle
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    // byte decode
    csvtok_decode u_decode (
        .in_byte      (in_byte_reg),
        .end_of_input (in_end_reg),
        .state        (state_reg),
        .state_next   (state_next),
        .token        (token)
    );

    // parser flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= advance && token.emit;
    end

    always_ff @(posedge clk)
    begin
        if (advance && token.emit)
        begin
            out_byte_reg <= token.data;
            out_kind_reg <= token.kind;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_kind_reg;

    // checks
    `ASSERT_ALWAYS(a_pending_in_quotes, clk, rst_n,
        !state_reg.quote_pending || state_reg.quoted_mode,
        "held quote outside quoted mode")
    `ASSERT_ALWAYS(a_cr_outside_quotes, clk, rst_n,
        !state_reg.cr_pending || !state_reg.quoted_mode,
        "CR pending while in quoted mode")
    `ASSERT_ALWAYS(a_token_byte_zero, clk, rst_n,
        !out_valid_reg || (out_kind_reg == csvtok_pkg::KIND_DATA) || (out_byte_reg == 8'h00),
        "non-data token carries a byte")
    `ASSERT_NEXT(a_stage_held, clk, rst_n,
        in_valid_reg && !out_free,
        in_valid_reg && $stable(in_byte_reg) && $stable(state_reg),
        "input stage lost while output stalled")

endmodule

`default_nettype wire
